[hdl/jdshft_pkg.sv]
// ----------------------------------------------------------------------------
// jdshft_pkg
// Shared types, field widths and calendar constants for the day number
// converter and date shifter.
// ----------------------------------------------------------------------------
package jdshft_pkg;

   // field widths
   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int WAIT_W  = 16;
   localparam int JDN_W   = 23;

   // cycles from an accepted transaction to its result strobe
   localparam int LATENCY = 10;

   // supported calendar range
   localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1583;
   localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
   localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;

   // day number bounds of the start date after range limiting
   localparam logic [JDN_W-1:0] START_JDN_MIN = 23'd2299238;
   localparam logic [JDN_W-1:0] START_JDN_MAX = 23'd5373484;

   typedef struct packed {
      logic [YEAR_W-1:0]  start_year;
      logic [MONTH_W-1:0] start_month;
      logic [DAY_W-1:0]   start_day;
      logic [WAIT_W-1:0]  wait_days;
   } req_type;

   typedef struct packed {
      logic [JDN_W-1:0]   start_day_number;
      logic [JDN_W-1:0]   launch_day_number;
      logic [YEAR_W-1:0]  launch_year;
      logic [MONTH_W-1:0] launch_month;
      logic [DAY_W-1:0]   launch_day;
   } rsp_type;

   // forward converter to inverse converter
   typedef struct packed {
      logic               valid;
      logic [JDN_W-1:0]   start_day_number;
      logic [WAIT_W-1:0]  wait_days;
   } fwd_type;

   // floor(30.6001 * k), days from the start of a March-based year
   function automatic logic [8:0] month_offset(input logic [3:0] k);
      logic [8:0] res;
      case (k)
         4'd0:    res = 9'd0;
         4'd1:    res = 9'd30;
         4'd2:    res = 9'd61;
         4'd3:    res = 9'd91;
         4'd4:    res = 9'd122;
         4'd5:    res = 9'd153;
         4'd6:    res = 9'd183;
         4'd7:    res = 9'd214;
         4'd8:    res = 9'd244;
         4'd9:    res = 9'd275;
         4'd10:   res = 9'd306;
         4'd11:   res = 9'd336;
         4'd12:   res = 9'd367;
         4'd13:   res = 9'd397;
         4'd14:   res = 9'd428;
         default: res = 9'd459;
      endcase
      return res;
   endfunction

endpackage

[hdl/jdshft_fwd.sv]
// ----------------------------------------------------------------------------
// jdshft_fwd
// Two-stage Gregorian date to Julian day number converter. Stage one limits
// the inputs, moves to a March-based year and forms the year, month and
// century terms; stage two sums them.
// ----------------------------------------------------------------------------
module jdshft_fwd (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  jdshft_pkg::req_type req_data,
   output jdshft_pkg::fwd_type fwd_out
);
   import jdshft_pkg::*;

   // y / 100 as a reciprocal multiply, exact for any 14 bit y
   localparam int          CENT_SHIFT = 21;
   localparam logic [14:0] CENT_MUL   = 15'((64'd1 << CENT_SHIFT) / 64'd100 + 64'd1);
   // day number offset with the constant 2 of the century term folded in
   localparam logic [23:0] FWD_BASE   = 24'd1720997;

   logic [YEAR_W-1:0]  year_sat;
   logic [MONTH_W-1:0] month_sat;
   logic [YEAR_W-1:0]  mar_year;
   logic [MONTH_W-1:0] mar_month;
   logic [28:0]        cent_prod;
   logic [23:0]        yd_prod;
   logic [21:0]        yd_in;
   logic [8:0]         mterm_in;
   logic [6:0]         cent_in;
   logic               s1_valid_ff;
   logic [21:0]        yd_ff;
   logic [8:0]         mterm_ff;
   logic [6:0]         cent_ff;
   logic [DAY_W-1:0]   day_ff;
   logic [WAIT_W-1:0]  wait_ff;
   logic [23:0]        jdn_sum;
   fwd_type            fwd_in;
   fwd_type            fwd_ff;

   // range limiting and March-based year
   always_comb begin
      if (req_data.start_year < YEAR_MIN) begin
         year_sat = YEAR_MIN;
      end else if (req_data.start_year > YEAR_MAX) begin
         year_sat = YEAR_MAX;
      end else begin
         year_sat = req_data.start_year;
      end
      if (req_data.start_month < MONTH_JAN) begin
         month_sat = MONTH_JAN;
      end else if (req_data.start_month > MONTH_DEC) begin
         month_sat = MONTH_DEC;
      end else begin
         month_sat = req_data.start_month;
      end
      if (month_sat > MONTH_FEB) begin
         mar_year  = year_sat;
         mar_month = month_sat;
      end else begin
         mar_year  = year_sat - 14'd1;
         mar_month = month_sat + MONTHS_PER_YEAR;
      end
   end

   // stage one terms: century, whole years, whole months
   assign cent_prod = 29'(mar_year) * 29'(CENT_MUL);
   assign cent_in   = cent_prod[CENT_SHIFT +: 7];
   assign yd_prod   = 24'(mar_year) * 24'd1461;
   assign yd_in     = yd_prod[23:2];
   assign mterm_in  = month_offset(4'(mar_month + 4'd1));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      yd_ff    <= yd_in;
      mterm_ff <= mterm_in;
      cent_ff  <= cent_in;
      day_ff   <= req_data.start_day;
      wait_ff  <= req_data.wait_days;
   end

   // stage two sum, century correction is 2 - a + a/4
   assign jdn_sum = 24'(yd_ff) + 24'(mterm_ff) + 24'(day_ff) + 24'(cent_ff[6:2])
                  + FWD_BASE - 24'(cent_ff);

   always_comb begin
      fwd_in.valid            = s1_valid_ff;
      fwd_in.start_day_number = jdn_sum[JDN_W-1:0];
      fwd_in.wait_days        = wait_ff;
   end

   // output register, only the valid bit is reset
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff.valid <= 1'b0;
      end else begin
         fwd_ff.valid <= fwd_in.valid;
      end
      fwd_ff.start_day_number <= fwd_in.start_day_number;
      fwd_ff.wait_days        <= fwd_in.wait_days;
   end

   assign fwd_out = fwd_ff;

   // limited inputs keep the day number inside the calendar range
   a_start_range: assert property (@(posedge clock) disable iff (reset)
      fwd_ff.valid |-> (fwd_ff.start_day_number >= START_JDN_MIN &&
                        fwd_ff.start_day_number <= START_JDN_MAX))
      else $error("start day number out of range");

endmodule

[hdl/jdshft_inv.sv]
// ----------------------------------------------------------------------------
// jdshft_inv
// Eight-stage day adder and Julian day number to Gregorian date converter.
// Each constant division is a reciprocal multiply chosen to be exact over
// its operand range, with a register after every multiply.
// ----------------------------------------------------------------------------
module jdshft_inv (
   input  logic                clock,
   input  logic                reset,
   input  jdshft_pkg::fwd_type fwd_in,
   output logic                rsp_strobe,
   output jdshft_pkg::rsp_type rsp_data
);
   import jdshft_pkg::*;

   // Gregorian century count: (4z - 7468865) / 146097
   localparam logic [23:0] ALPHA_BASE  = 24'd7468865;
   localparam int          ALPHA_SHIFT = 42;
   localparam logic [24:0] ALPHA_MUL   = 25'((64'd1 << ALPHA_SHIFT) / 64'd146097 + 64'd1);
   // year count: (100 * c2 - 12210) / 36525
   localparam logic [29:0] YEAR_BASE   = 30'd12210;
   localparam int          YEAR_SHIFT  = 46;
   localparam logic [30:0] YEAR_MUL    = 31'((64'd1 << YEAR_SHIFT) / 64'd36525 + 64'd1);
   // month count: 10000 * d / 306001
   localparam int          MON_SHIFT   = 28;
   localparam logic [23:0] MON_MUL     =
      24'(((64'd1 << MON_SHIFT) * 64'd10000) / 64'd306001 + 64'd1);
   localparam logic [22:0] C2_BASE     = 23'd1525;
   localparam logic [3:0]  MON_WRAP    = 4'd14;
   localparam logic [13:0] YEAR_OFS_A  = 14'd4716;
   localparam logic [13:0] YEAR_OFS_B  = 14'd4715;

   // valid bits of stages three to ten
   logic [7:0]         valid_ff;

   logic [JDN_W-1:0]   s3_start_ff, s4_start_ff, s5_start_ff, s6_start_ff;
   logic [JDN_W-1:0]   s7_start_ff, s8_start_ff, s9_start_ff;
   logic [JDN_W-1:0]   s3_launch_ff, s4_launch_ff, s5_launch_ff, s6_launch_ff;
   logic [JDN_W-1:0]   s7_launch_ff, s8_launch_ff, s9_launch_ff;

   logic [JDN_W-1:0]   launch_in;
   logic [24:0]        xa_wide;
   logic [23:0]        xa_in, xa_ff;
   logic [48:0]        alpha_prod;
   logic [6:0]         alpha_in, alpha_ff;
   logic [22:0]        c2_in, s5_c2_ff, s6_c2_ff, s7_c2_ff;
   logic [29:0]        x3_in, x3_ff;
   logic [60:0]        c3_prod;
   logic [13:0]        c3_in, s7_c3_ff, s8_c3_ff, s9_c3_ff;
   logic [24:0]        c4_prod;
   logic [22:0]        dd_wide;
   logic [8:0]         dd_in, s8_dd_ff, s9_dd_ff;
   logic [32:0]        c5_prod;
   logic [3:0]         c5_in, c5_ff;
   rsp_type            rsp_in, rsp_ff;

   // valid shift line
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[6:0], fwd_in.valid};
      end
   end

   // stage three: add the wait and form the century dividend
   assign launch_in = fwd_in.start_day_number + JDN_W'(fwd_in.wait_days);
   assign xa_wide   = {launch_in, 2'b00} - 25'(ALPHA_BASE);
   assign xa_in     = xa_wide[23:0];

   // stage four: century count
   assign alpha_prod = 49'(xa_ff) * 49'(ALPHA_MUL);
   assign alpha_in   = alpha_prod[ALPHA_SHIFT +: 7];

   // stage five: Gregorian correction
   assign c2_in = s4_launch_ff + 23'(alpha_ff) - 23'(alpha_ff[6:2]) + C2_BASE;

   // stage six: year dividend
   assign x3_in = 30'(s5_c2_ff) * 30'd100 - YEAR_BASE;

   // stage seven: year count
   assign c3_prod = 61'(x3_ff) * 61'(YEAR_MUL);
   assign c3_in   = c3_prod[YEAR_SHIFT +: 14];

   // stage eight: days into the March-based year
   assign c4_prod = 25'(s7_c3_ff) * 25'd1461;
   assign dd_wide = s7_c2_ff - c4_prod[24:2];
   assign dd_in   = dd_wide[8:0];

   // stage nine: month count
   assign c5_prod = 33'(s8_dd_ff) * 33'(MON_MUL);
   assign c5_in   = c5_prod[MON_SHIFT +: 4];

   // stage ten: calendar fields
   always_comb begin
      logic [8:0] day_wide;
      day_wide                 = s9_dd_ff - month_offset(c5_ff);
      rsp_in.start_day_number  = s9_start_ff;
      rsp_in.launch_day_number = s9_launch_ff;
      rsp_in.launch_day        = day_wide[DAY_W-1:0];
      if (c5_ff < MON_WRAP) begin
         rsp_in.launch_month = c5_ff - 4'd1;
      end else begin
         rsp_in.launch_month = c5_ff - 4'd13;
      end
      if (rsp_in.launch_month > MONTH_FEB) begin
         rsp_in.launch_year = s9_c3_ff - YEAR_OFS_A;
      end else begin
         rsp_in.launch_year = s9_c3_ff - YEAR_OFS_B;
      end
   end

   // payload pipeline
   always_ff @(posedge clock) begin
      s3_start_ff  <= fwd_in.start_day_number;
      s3_launch_ff <= launch_in;
      xa_ff        <= xa_in;

      s4_start_ff  <= s3_start_ff;
      s4_launch_ff <= s3_launch_ff;
      alpha_ff     <= alpha_in;

      s5_start_ff  <= s4_start_ff;
      s5_launch_ff <= s4_launch_ff;
      s5_c2_ff     <= c2_in;

      s6_start_ff  <= s5_start_ff;
      s6_launch_ff <= s5_launch_ff;
      s6_c2_ff     <= s5_c2_ff;
      x3_ff        <= x3_in;

      s7_start_ff  <= s6_start_ff;
      s7_launch_ff <= s6_launch_ff;
      s7_c2_ff     <= s6_c2_ff;
      s7_c3_ff     <= c3_in;

      s8_start_ff  <= s7_start_ff;
      s8_launch_ff <= s7_launch_ff;
      s8_c3_ff     <= s7_c3_ff;
      s8_dd_ff     <= dd_in;

      s9_start_ff  <= s8_start_ff;
      s9_launch_ff <= s8_launch_ff;
      s9_c3_ff     <= s8_c3_ff;
      s9_dd_ff     <= s8_dd_ff;
      c5_ff        <= c5_in;

      rsp_ff       <= rsp_in;
   end

   assign rsp_strobe = valid_ff[7];
   assign rsp_data   = rsp_ff;

   // a converted date is always a real calendar date
   a_month_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_ff.launch_month >= MONTH_JAN &&
                      rsp_ff.launch_month <= MONTH_DEC))
      else $error("launch month out of range");

   a_day_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_ff.launch_day >= 5'd1 && rsp_ff.launch_day <= 5'd31))
      else $error("launch day out of range");

   // start and launch numbers stay paired through the pipe
   a_launch_order: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_ff.launch_day_number >= rsp_ff.start_day_number))
      else $error("launch day number precedes start day number");

endmodule

[hdl/julian_day_date_shift.sv]
// ----------------------------------------------------------------------------
// julian_day_date_shift
// Gregorian date to Julian day number, plus a day offset, and back to a
// Gregorian date.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_data with a date and a wait in days and pulse start. A
//   transaction is taken at each rising edge with start high and busy low.
//   busy is never raised: the pipeline takes one transaction in every cycle.
//   Year is limited to 1583..9999 and month to 1..12; a day past the end of
//   its month runs on into the next one.
//   The result is on rsp_data for exactly one cycle, marked by rsp_strobe;
//   the pipeline has two stages for the date to day number conversion, one
//   for the day addition and seven for the inverse conversion.
//   Throughput is one transaction per cycle, set by the fully pipelined
//   reciprocal multipliers. Results leave in the order taken.
//   The receiver has no way to hold results back and must take each one in
//   the cycle it is shown.
//   Synchronous reset clears all valid bits, so no strobe follows reset
//   until a new transaction has gone through; data registers are not reset.
// ----------------------------------------------------------------------------
module julian_day_date_shift (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  jdshft_pkg::req_type req_data,
   output logic                rsp_strobe,
   output jdshft_pkg::rsp_type rsp_data
);
   import jdshft_pkg::*;

   logic    req_accept;
   fwd_type fwd_link;

   // the pipe never stalls, so a transaction is taken whenever offered
   assign busy       = 1'b0;
   assign req_accept = start & ~busy;

   // date to day number
   jdshft_fwd u_fwd (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_accept),
      .req_data  (req_data),
      .fwd_out   (fwd_link)
   );

   // day addition and day number to date
   jdshft_inv u_inv (
      .clock      (clock),
      .reset      (reset),
      .fwd_in     (fwd_link),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // every result strobe goes back to a transaction taken one latency earlier
   a_strobe_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(req_accept, LATENCY))
      else $error("result strobe without a matching transaction");

endmodule
